@@ rtl/rayc_pkg.sv @@
// Shared types and constants for the grid DDA column ray caster.
// Used by the controller, datapath, divider and top level; depends on nothing.
`default_nettype none

package rayc_pkg;

  localparam int MAP_SIZE      = 32;
  localparam int MAP_BITS      = 5;
  localparam int MAP_DEPTH     = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_BITS     = 2 * MAP_BITS;
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int FRAC_BITS     = 16;

  localparam int STEP_LIMIT = MAP_SIZE * 2;
  localparam int STEP_BITS  = 7;

  localparam int DIV_N        = 34;   // dividend and quotient width
  localparam int DIV_D        = 36;   // divisor width
  localparam int DIV_CNT_BITS = 6;

  // column scale 2*col*2^FRAC_BITS/SCREEN_WIDTH = col*2^10/5, taken as col*ceil(2^23/5) >> 13
  localparam int CAM_RECIP  = 1677722;
  localparam int CAM_SHIFT  = 13;
  localparam int CAM_PROD_W = 31;

  localparam int DELTA_W = FRAC_BITS + 12;
  localparam int SIDE_W  = 36;
  localparam int DIST_W  = 22;
  localparam int LH_W    = 10;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef enum logic [2:0] {
    REG_CAMERA_X  = 3'd0,
    REG_CAMERA_Y  = 3'd1,
    REG_VIEW_DIR_X = 3'd2,
    REG_VIEW_DIR_Y = 3'd3,
    REG_CAM_PLANE_X = 3'd4,
    REG_CAM_PLANE_Y = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_DX   = 2'd1,
    DIV_DY   = 2'd2,
    DIV_LH   = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     clear_step;
    logic     wr_cell;
    logic     ld_req;
    logic     div_start;
    div_sel_t div_sel;
    logic     ld_cam;
    logic     ld_prod;
    logic     ld_ray;
    logic     ld_dx;
    logic     ld_dy;
    logic     ld_side;
    logic     step;
    logic     check;
    logic     ld_lh;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic hit;
    logic bound;
    logic out_free;
  } stat_t;

  function automatic logic [23:0] wall_color(input logic [2:0] code);
    logic [23:0] rgb;
    case (code)
      3'd1:    rgb = 24'hFF0000;
      3'd2:    rgb = 24'h00FF00;
      3'd3:    rgb = 24'h0000FF;
      3'd4:    rgb = 24'hFFFFFF;
      3'd5:    rgb = 24'hFFFF00;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rayc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module rayc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/rayc_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions of a cast.
// Depends on rayc_pkg.
`default_nettype none

module rayc_div
  import rayc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_N-1:0] dividend,
  input  wire logic [DIV_D-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [DIV_N-1:0] quotient
);

  logic [DIV_D-1:0]        rem;
  logic [DIV_D-1:0]        dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_D:0]          trial;
  logic [DIV_D:0]          diff;
  logic                    ge;

  assign trial = {rem, quotient[DIV_N-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
      quotient <= {quotient[DIV_N-2:0], ge};
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

@@ rtl/rayc_datapath.sv @@
// Datapath of the ray caster: camera registers, map RAM, ray setup, DDA walk, span.
// Depends on rayc_pkg, rayc_ram and rayc_div; driven by rayc_ctrl commands.
`default_nettype none

module rayc_datapath
  import rayc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [20:0] cfg_data,
  input  wire logic [9:0]  column,
  input  wire logic [4:0]  cell_x,
  input  wire logic [4:0]  cell_y,
  input  wire logic [2:0]  cell_code,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [9:0]       out_column,
  output logic             hit_found,
  output logic             wall_side,
  output logic [2:0]       wall_code,
  output logic [21:0]      wall_distance,
  output logic [8:0]       span_start,
  output logic [8:0]       span_end,
  output logic [23:0]      wall_rgb
);

  logic [20:0]        camera_x, camera_y;
  logic signed [17:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;

  logic [9:0]          req_col;
  logic [CAM_PROD_W-1:0] cam_prod;
  logic signed [18:0]  cam;
  logic signed [36:0]  prod_x, prod_y;
  logic signed [21:0]  rdx, rdy;
  logic [21:0]         abs_rdx, abs_rdy;
  logic [DELTA_W-1:0]  dx, dy;
  logic [SIDE_W-1:0]   sdx, sdy, perp;
  logic signed [7:0]   mx, my, mx_next, my_next, step_x, step_y;
  logic                go_x, side, in_grid, hit_r;
  logic [2:0]          code_r;
  logic [STEP_BITS-1:0] nstep;
  logic [LH_W-1:0]     lh;
  logic [ADDR_BITS-1:0] clr_cnt;

  logic [DIV_N-1:0] div_dvd, div_q;
  logic [DIV_D-1:0] div_dvs;
  logic             div_busy, div_done;

  logic             ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [2:0]       ram_wdata, ram_rdata;

  logic [FRAC_BITS:0]           ofx, ofy;
  logic [FRAC_BITS+DELTA_W:0]   side_mx, side_my;
  logic [LH_W-2:0]              half;
  logic signed [LH_W:0]         ds;
  logic [LH_W:0]                de;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x    <= 21'd131072;
      camera_y    <= 21'd131072;
      view_dir_x  <= -18'sd65536;
      view_dir_y  <= '0;
      cam_plane_x <= '0;
      cam_plane_y <= 18'sd43254;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAMERA_X:    camera_x    <= cfg_data;
        REG_CAMERA_Y:    camera_y    <= cfg_data;
        REG_VIEW_DIR_X:  view_dir_x  <= $signed(cfg_data[17:0]);
        REG_VIEW_DIR_Y:  view_dir_y  <= $signed(cfg_data[17:0]);
        REG_CAM_PLANE_X: cam_plane_x <= $signed(cfg_data[17:0]);
        REG_CAM_PLANE_Y: cam_plane_y <= $signed(cfg_data[17:0]);
        default: ;
      endcase
    end
  end

  // Map RAM: clearing pass after reset, then cell writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign ram_we    = cmd.clear_step
                   | (cmd.wr_cell && (32'(cell_x) < MAP_SIZE) && (32'(cell_y) < MAP_SIZE));
  assign ram_waddr = cmd.clear_step ? clr_cnt : {cell_x[MAP_BITS-1:0], cell_y[MAP_BITS-1:0]};
  assign ram_wdata = cmd.clear_step ? 3'd0 : cell_code;
  assign ram_raddr = {mx_next[MAP_BITS-1:0], my_next[MAP_BITS-1:0]};

  rayc_ram #(.WIDTH(3), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared divider operands
  assign abs_rdx = rdx[21] ? 22'(-rdx) : 22'(rdx);
  assign abs_rdy = rdy[21] ? 22'(-rdy) : 22'(rdy);
  assign perp    = side ? sdy - SIDE_W'(dy) : sdx - SIDE_W'(dx);

  always_comb begin
    case (cmd.div_sel)
      DIV_DX: begin
        div_dvd = DIV_N'(1) << (2 * FRAC_BITS);
        div_dvs = DIV_D'(abs_rdx);
      end
      DIV_DY: begin
        div_dvd = DIV_N'(1) << (2 * FRAC_BITS);
        div_dvs = DIV_D'(abs_rdy);
      end
      DIV_LH: begin
        div_dvd = DIV_N'(SCREEN_HEIGHT) << FRAC_BITS;
        div_dvs = perp;
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  rayc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // column scale by reciprocal multiply
  assign cam_prod = CAM_PROD_W'(req_col) * CAM_PROD_W'(CAM_RECIP);

  // Ray setup
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_col <= column;
    end
    if (cmd.ld_cam) begin
      cam <= $signed({1'b0, cam_prod[CAM_SHIFT +: 18]}) - (19'sd1 <<< FRAC_BITS);
    end
    if (cmd.ld_prod) begin
      prod_x <= cam_plane_x * cam;
      prod_y <= cam_plane_y * cam;
    end
    if (cmd.ld_ray) begin
      rdx <= $signed({{4{view_dir_x[17]}}, view_dir_x} + {prod_x[36], prod_x[36:FRAC_BITS]});
      rdy <= $signed({{4{view_dir_y[17]}}, view_dir_y} + {prod_y[36], prod_y[36:FRAC_BITS]});
    end
    // saturate the step distance
    if (cmd.ld_dx) begin
      dx <= (|div_q[DIV_N-1:DELTA_W]) ? '1 : div_q[DELTA_W-1:0];
    end
    if (cmd.ld_dy) begin
      dy <= (|div_q[DIV_N-1:DELTA_W]) ? '1 : div_q[DELTA_W-1:0];
    end
    if (cmd.ld_lh) begin
      lh <= (div_q < DIV_N'(2 * SCREEN_HEIGHT)) ? LH_W'(div_q) : LH_W'(2 * SCREEN_HEIGHT);
    end
  end

  assign ofx = rdx[21] ? {1'b0, camera_x[FRAC_BITS-1:0]}
                       : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, camera_x[FRAC_BITS-1:0]};
  assign ofy = rdy[21] ? {1'b0, camera_y[FRAC_BITS-1:0]}
                       : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, camera_y[FRAC_BITS-1:0]};
  assign side_mx = ofx * dx;
  assign side_my = ofy * dy;

  // DDA walk
  assign step_x  = rdx[21] ? -8'sd1 : 8'sd1;
  assign step_y  = rdy[21] ? -8'sd1 : 8'sd1;
  assign go_x    = sdx < sdy;
  assign mx_next = go_x ? mx + step_x : mx;
  assign my_next = go_x ? my : my + step_y;

  always_ff @(posedge clk) begin
    if (cmd.ld_side) begin
      sdx   <= SIDE_W'(side_mx >> FRAC_BITS);
      sdy   <= SIDE_W'(side_my >> FRAC_BITS);
      mx    <= $signed({3'b000, camera_x[20:FRAC_BITS]});
      my    <= $signed({3'b000, camera_y[20:FRAC_BITS]});
      nstep <= '0;
      hit_r <= 1'b0;
    end else if (cmd.step) begin
      if (go_x) begin
        sdx  <= sdx + SIDE_W'(dx);
        side <= 1'b0;
      end else begin
        sdy  <= sdy + SIDE_W'(dy);
        side <= 1'b1;
      end
      mx      <= mx_next;
      my      <= my_next;
      nstep   <= nstep + 1'b1;
      in_grid <= (mx_next[7:MAP_BITS] == '0) && (my_next[7:MAP_BITS] == '0);
    end else if (cmd.check) begin
      hit_r  <= stat.hit;
      code_r <= ram_rdata;
    end
  end

  // Span
  assign half = lh[LH_W-1:1];
  assign ds   = $signed((LH_W+1)'(SCREEN_HEIGHT / 2)) - $signed({2'b00, half});
  assign de   = (LH_W+1)'(SCREEN_HEIGHT / 2) + (LH_W+1)'(half);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_column <= req_col;
      hit_found  <= hit_r;
      if (hit_r) begin
        wall_side     <= side;
        wall_code     <= code_r;
        wall_distance <= (perp > SIDE_W'(4194303)) ? '1 : perp[DIST_W-1:0];
        span_start    <= (ds <= 0) ? 9'd0 : ds[8:0];
        span_end      <= (de >= (LH_W+1)'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT - 1) : de[8:0];
        wall_rgb      <= wall_color(code_r);
      end else begin
        wall_side     <= 1'b0;
        wall_code     <= '0;
        wall_distance <= '0;
        span_start    <= '0;
        span_end      <= '0;
        wall_rgb      <= '0;
      end
    end
  end

  assign stat.clear_last = clr_cnt == '1;
  assign stat.div_done   = div_done;
  assign stat.hit        = in_grid && (ram_rdata != 3'd0);
  assign stat.bound      = nstep == STEP_BITS'(STEP_LIMIT);
  assign stat.out_free   = !out_valid || out_ready;

`ifndef SYNTH
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> nstep < STEP_BITS'(STEP_LIMIT))
    else $error("walk stepped past its bound");
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !cmd.wr_cell)
    else $error("cell write during clearing pass");
`endif

endmodule

`default_nettype wire

@@ rtl/rayc_ctrl.sv @@
// Controller state machine for the ray caster: sequences clear, setup, walk, output.
// Depends on rayc_pkg; talks to rayc_datapath through cmd_t and stat_t.
`default_nettype none

module rayc_ctrl
  import rayc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  command,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_CAM   = 15'h0004,
    S_PROD  = 15'h0008,
    S_RAY   = 15'h0010,
    S_DX    = 15'h0020,
    S_DX_W  = 15'h0040,
    S_DY    = 15'h0080,
    S_DY_W  = 15'h0100,
    S_SIDE  = 15'h0200,
    S_STEP  = 15'h0400,
    S_CHECK = 15'h0800,
    S_LH    = 15'h1000,
    S_LH_W  = 15'h2000,
    S_DONE  = 15'h4000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_NONE;
    in_ready    = 1'b0;
    state_next  = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_CAST) begin
            cmd.ld_req = 1'b1;
            state_next = S_CAM;
          end else begin
            cmd.wr_cell = 1'b1;
          end
        end
      end
      S_CAM: begin
        cmd.ld_cam = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.ld_prod = 1'b1;
        state_next  = S_RAY;
      end
      S_RAY: begin
        cmd.ld_ray = 1'b1;
        state_next = S_DX;
      end
      S_DX: begin
        cmd.div_sel   = DIV_DX;
        cmd.div_start = 1'b1;
        state_next    = S_DX_W;
      end
      S_DX_W: begin
        cmd.div_sel = DIV_DX;
        if (stat.div_done) begin
          cmd.ld_dx  = 1'b1;
          state_next = S_DY;
        end
      end
      S_DY: begin
        cmd.div_sel   = DIV_DY;
        cmd.div_start = 1'b1;
        state_next    = S_DY_W;
      end
      S_DY_W: begin
        cmd.div_sel = DIV_DY;
        if (stat.div_done) begin
          cmd.ld_dy  = 1'b1;
          state_next = S_SIDE;
        end
      end
      S_SIDE: begin
        cmd.ld_side = 1'b1;
        state_next  = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // map data for the entered cell is ready now
        cmd.check = 1'b1;
        if (stat.hit) state_next = S_LH;
        else if (stat.bound) state_next = S_DONE;
        else state_next = S_STEP;
      end
      S_LH: begin
        cmd.div_sel   = DIV_LH;
        cmd.div_start = 1'b1;
        state_next    = S_LH_W;
      end
      S_LH_W: begin
        cmd.div_sel = DIV_LH;
        if (stat.div_done) begin
          cmd.ld_lh  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_out_free: assert property (@(posedge clk) disable iff (rst) cmd.ld_out |-> stat.out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

@@ rtl/grid_dda_column_raycaster.sv @@
// Grid DDA column ray caster. After reset the 32x32 map is cleared in a pass over its 1024
// cells during which no request is taken (configuration writes still land). A cell write
// request is written straight from the idle state. A cast request scales its column by a
// reciprocal multiply, then runs up to three divisions on one shared 1-bit-per-cycle divider
// (two step distances, and the line height once a wall is hit) plus setup, then walks the
// grid through S_STEP then S_CHECK for each grid step, limited by the registered map RAM
// read; a finished cast waits in S_DONE until out_ready frees the previous result.
// Requests are taken only when no cast is in flight; a finished result waits in the output
// register. Depends on rayc_pkg, rayc_ctrl, rayc_datapath.
`default_nettype none

module grid_dda_column_raycaster
  import rayc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [20:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [9:0]  column,
  input  wire logic [4:0]  cell_x,
  input  wire logic [4:0]  cell_y,
  input  wire logic [2:0]  cell_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_column,
  output logic             hit_found,
  output logic             wall_side,
  output logic [2:0]       wall_code,
  output logic [21:0]      wall_distance,
  output logic [8:0]       span_start,
  output logic [8:0]       span_end,
  output logic [23:0]      wall_rgb
);

  cmd_t  cmd;
  stat_t stat;

  rayc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rayc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .column        (column),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_code     (cell_code),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_column    (out_column),
    .hit_found     (hit_found),
    .wall_side     (wall_side),
    .wall_code     (wall_code),
    .wall_distance (wall_distance),
    .span_start    (span_start),
    .span_end      (span_end),
    .wall_rgb      (wall_rgb)
  );

endmodule

`default_nettype wire

@@ tb/tb_grid_dda_column_raycaster.sv @@
// Self-checking testbench for grid_dda_column_raycaster: map writes and column casts
// driven over valid/ready, casts predicted in-bench and compared on all result fields.
// Depends on rayc_pkg and the RTL of the ray caster.
`default_nettype none

module tb_grid_dda_column_raycaster
  import rayc_pkg::*;
();

  typedef struct packed {
    logic       cmd;
    logic [9:0] col;
    logic [4:0] cx;
    logic [4:0] cy;
    logic [2:0] code;
  } req_t;

  typedef struct packed {
    logic [9:0]  col;
    logic        hit;
    logic        side;
    logic [2:0]  code;
    logic [21:0] wdist;
    logic [8:0]  ss;
    logic [8:0]  se;
    logic [23:0] rgb;
  } cast_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [20:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [9:0] column = '0;
  logic [4:0] cell_x = '0, cell_y = '0;
  logic [2:0] cell_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_column;
  logic hit_found, wall_side;
  logic [2:0] wall_code;
  logic [21:0] wall_distance;
  logic [8:0] span_start, span_end;
  logic [23:0] wall_rgb;

  grid_dda_column_raycaster u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [2:0] grid [MAP_DEPTH];
  logic [20:0] pos_x, pos_y;
  logic signed [17:0] dir_x, dir_y, pln_x, pln_y;

  req_t  pending_reqs[$];
  cast_t expected_casts[$];
  int    mismatches = 0;
  bit    calm = 1'b0;
  int    in_gap = 0, out_gap = 0;

  function automatic longint floor_sh(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint delta_of(longint r);
    longint a, q;
    if (r == 0) return (64'sd1 << DELTA_W) - 1;
    a = r < 0 ? -r : r;
    q = (64'sd1 << (2 * FRAC_BITS)) / a;
    return q > ((64'sd1 << DELTA_W) - 1) ? ((64'sd1 << DELTA_W) - 1) : q;
  endfunction

  function automatic cast_t cast_column(logic [9:0] col);
    cast_t r;
    longint cam, rdx, rdy, dx, dy, sdx, sdy, fx, fy, perp, lh, ds, de;
    int mx, my, sx, sy;
    bit hit, side;
    logic [2:0] code;
    r = '0;
    r.col = col;
    cam = ((2 * longint'(col)) << FRAC_BITS) / SCREEN_WIDTH - (64'sd1 << FRAC_BITS);
    rdx = longint'(dir_x) + floor_sh(longint'(pln_x) * cam);
    rdy = longint'(dir_y) + floor_sh(longint'(pln_y) * cam);
    dx = delta_of(rdx);
    dy = delta_of(rdy);
    mx = pos_x >> FRAC_BITS;
    my = pos_y >> FRAC_BITS;
    fx = pos_x & 16'hFFFF;
    fy = pos_y & 16'hFFFF;
    if (rdx < 0) begin sx = -1; sdx = (fx * dx) >> FRAC_BITS; end
    else begin sx = 1; sdx = (((64'sd1 << FRAC_BITS) - fx) * dx) >> FRAC_BITS; end
    if (rdy < 0) begin sy = -1; sdy = (fy * dy) >> FRAC_BITS; end
    else begin sy = 1; sdy = (((64'sd1 << FRAC_BITS) - fy) * dy) >> FRAC_BITS; end
    hit = 0;
    side = 0;
    code = 0;
    for (int i = 0; i < STEP_LIMIT && !hit; i++) begin
      if (sdx < sdy) begin sdx += dx; mx += sx; side = 0; end
      else begin sdy += dy; my += sy; side = 1; end
      // cells off the grid read as empty
      if (mx >= 0 && my >= 0 && mx < MAP_SIZE && my < MAP_SIZE) begin
        code = grid[mx * MAP_SIZE + my];
        hit = code != 0;
      end
    end
    if (!hit) return r;
    perp = side ? sdy - dy : sdx - dx;
    lh = 2 * SCREEN_HEIGHT;
    if (perp != 0 && ((longint'(SCREEN_HEIGHT) << FRAC_BITS) / perp) < lh)
      lh = (longint'(SCREEN_HEIGHT) << FRAC_BITS) / perp;
    ds = SCREEN_HEIGHT / 2 - lh / 2;
    de = SCREEN_HEIGHT / 2 + lh / 2;
    if (ds <= 0) ds = 0;
    if (de >= SCREEN_HEIGHT) de = SCREEN_HEIGHT - 1;
    r.hit = 1;
    r.side = side;
    r.code = code;
    r.wdist = perp > 4194303 ? 22'h3FFFFF : perp[21:0];
    r.ss = ds[8:0];
    r.se = de[8:0];
    case (code)
      3'd1: r.rgb = 24'hFF0000;
      3'd2: r.rgb = 24'h00FF00;
      3'd3: r.rgb = 24'h0000FF;
      3'd4: r.rgb = 24'hFFFFFF;
      3'd5: r.rgb = 24'hFFFF00;
      default: r.rgb = 24'h000000;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      if (command == CMD_WRITE) grid[{cell_x, cell_y}] = cell_code;
      else expected_casts.push_back(cast_column(column));
      if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 12);
      if (pending_reqs.size() > 0 && in_gap == 0) begin
        {command, column, cell_x, cell_y, cell_code} <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) in_gap--;
      else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        {command, column, cell_x, cell_y, cell_code} <= pending_reqs.pop_front();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cast_t got, exp_c;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_column, hit_found, wall_side, wall_code, wall_distance,
               span_start, span_end, wall_rgb};
        if (expected_casts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %p", got);
        end else begin
          exp_c = expected_casts.pop_front();
          if (got !== exp_c) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch col %0d: exp %p got %p",
                                           exp_c.col, exp_c, got);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [20:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CAMERA_X:    pos_x = val;
      REG_CAMERA_Y:    pos_y = val;
      REG_VIEW_DIR_X:  dir_x = val[17:0];
      REG_VIEW_DIR_Y:  dir_y = val[17:0];
      REG_CAM_PLANE_X: pln_x = val[17:0];
      default:         pln_y = val[17:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_casts.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic req_t wr_req(int x, int y, int c);
    return {CMD_WRITE, 10'd0, 5'(x), 5'(y), 3'(c)};
  endfunction

  function automatic req_t cast_req(int c);
    return {CMD_CAST, 10'(c), 5'($urandom), 5'($urandom), 3'($urandom)};
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        pending_reqs.push_back(wr_req($urandom, $urandom, $urandom_range(0, 3) == 0 ? 0 :
                                      $urandom_range(1, 7)));
      else
        pending_reqs.push_back(cast_req($urandom_range(0, 9) == 0 ? $urandom_range(640, 1023)
                                        : $urandom_range(0, 639)));
    end
  endtask

  task automatic random_view();
    write_reg(REG_CAMERA_X, 21'($urandom_range(1, 30) << 16 | $urandom_range(0, 65535)));
    write_reg(REG_CAMERA_Y, 21'($urandom_range(1, 30) << 16 | $urandom_range(0, 65535)));
    write_reg(REG_VIEW_DIR_X, 21'($urandom));
    write_reg(REG_VIEW_DIR_Y, 21'($urandom));
    write_reg(REG_CAM_PLANE_X, 21'($urandom));
    write_reg(REG_CAM_PLANE_Y, 21'($urandom));
  endtask

  initial begin
    foreach (grid[i]) grid[i] = '0;
    pos_x = 21'd131072;
    pos_y = 21'd131072;
    dir_x = -18'sd65536;
    dir_y = '0;
    pln_x = '0;
    pln_y = 18'sd43254;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: border walls, all codes, a miss, extreme columns
    pending_reqs.push_back(cast_req(0));
    for (int c = 1; c <= 7; c++) pending_reqs.push_back(wr_req(0, c, c));
    pending_reqs.push_back(wr_req(31, 31, 7));
    pending_reqs.push_back(wr_req(0, 3, 0));
    pending_reqs.push_back(cast_req(0));
    pending_reqs.push_back(cast_req(320));
    pending_reqs.push_back(cast_req(639));
    pending_reqs.push_back(cast_req(1023));
    drain();

    // extremes: camera at the far corner, max and min vectors, zero direction
    write_reg(REG_CAMERA_X, 21'h1FFFFF);
    write_reg(REG_CAMERA_Y, 21'h1FFFFF);
    write_reg(REG_VIEW_DIR_X, 21'h1FFFF);
    write_reg(REG_VIEW_DIR_Y, 21'h20000);
    write_reg(REG_CAM_PLANE_X, 21'h0);
    write_reg(REG_CAM_PLANE_Y, 21'h0);
    pending_reqs.push_back(cast_req(0));
    pending_reqs.push_back(cast_req(320));
    drain();
    write_reg(REG_CAMERA_X, 21'h0);
    write_reg(REG_CAMERA_Y, 21'h0);
    write_reg(REG_VIEW_DIR_X, 21'h0);
    write_reg(REG_VIEW_DIR_Y, 21'h0);
    write_reg(REG_CAM_PLANE_X, 21'h20000);
    write_reg(REG_CAM_PLANE_Y, 21'h1FFFF);
    pending_reqs.push_back(cast_req(320));
    pending_reqs.push_back(cast_req(1));
    drain();

    for (int p = 0; p < 10; p++) begin
      random_view();
      if (p == 9) calm = 1'b1;
      random_phase(50);
      drain();
    end
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/rayc_pkg.sv
rtl/rayc_ram.sv
rtl/rayc_div.sv
rtl/rayc_datapath.sv
rtl/rayc_ctrl.sv
rtl/grid_dda_column_raycaster.sv
tb/tb_grid_dda_column_raycaster.sv
